@@ sv/ctlb_pkg.sv @@
// Shared types and constants for the cursor text line buffer.
`default_nettype none
package ctlb_pkg;

  // Key codes that move the cursor instead of inserting
  localparam logic [7:0] KEY_HOME = 8'h5B;
  localparam logic [7:0] KEY_END  = 8'h5D;

  // Request function codes
  localparam logic FUNC_KEY = 1'b0;
  localparam logic FUNC_EOL = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] key_byte;
  } ctlb_in_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_line;
    logic       line_empty;
    logic       overflow_seen;
  } ctlb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_LINK,
    ST_INS_CUR,
    ST_EMIT
  } ctlb_state_t;

endpackage : ctlb_pkg
`default_nettype wire

@@ sv/cursor_text_line_buffer_core.sv @@
// Top level: linked-list line buffer with insertion cursor and line walk.
// Home/end key: busy stays low.
// Character key: busy in ST_INS_LINK, then in ST_INS_CUR when the cursor is not at the
//   head, set by the single write port of the link memory. A full line sets overflow.
// End of line with n characters: n results back to back through the memory read register and
//   the result register; an empty line gives one result in the next cycle. The walk is bound by
//   one link memory read per character. The receiver cannot stall the results.
// Reset (rst_n low, synchronous) empties the line; memory contents are not cleared.
`default_nettype none
module cursor_text_line_buffer_core #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ctlb_pkg::ctlb_in_t in_req,
  output logic                    out_valid,
  output ctlb_pkg::ctlb_out_t     out_res
);
  import ctlb_pkg::*;

  localparam int SLOT_W = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [SLOT_W-1:0] CAP = SLOT_W'(LINE_CAPACITY);
  localparam logic [SLOT_W-1:0] ONE = SLOT_W'(1);

  ctlb_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] cursor_r, cursor_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0] count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [SLOT_W-1:0] succ_r, succ_nxt;
  logic              out_valid_r, out_valid_nxt;
  ctlb_out_t         out_res_r, out_res_nxt;

  logic              accept;
  logic [SLOT_W-1:0] new_slot;
  logic [SLOT_W-1:0] cur_m1, head_m1, lrd_m1, new_m1;
  logic              char_we, link_we;
  logic [ADDR_W-1:0] char_waddr, link_waddr, rd_addr;
  logic [7:0]        char_wdata, char_rdata;
  logic [SLOT_W-1:0] link_wdata, link_rdata;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign new_slot = count_r + ONE;
  assign cur_m1   = cursor_r - ONE;
  assign head_m1  = head_r - ONE;
  assign lrd_m1   = link_rdata - ONE;
  assign new_m1   = new_slot - ONE;

  // Character memory: character of slot s at index s-1
  ctlb_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_waddr),
    .wdata (char_wdata),
    .raddr (rd_addr),
    .rdata (char_rdata)
  );

  // Link memory: successor of slot s at index s-1; head link lives in head_r
  ctlb_ram #(.WIDTH(SLOT_W), .DEPTH(LINE_CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  // Sequencer: next state, memory ports and result register
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cursor_nxt    = cursor_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    succ_nxt      = succ_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    char_we       = 1'b0;
    char_waddr    = count_r[ADDR_W-1:0];
    char_wdata    = in_req.key_byte;
    link_we       = 1'b0;
    link_waddr    = new_m1[ADDR_W-1:0];
    link_wdata    = succ_r;
    rd_addr       = cur_m1[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.func == FUNC_KEY) begin
            if (in_req.key_byte == KEY_HOME) begin
              cursor_nxt = '0;
            end else if (in_req.key_byte == KEY_END) begin
              cursor_nxt = tail_r;
            end else if (count_r >= CAP) begin
              ovf_nxt = 1'b1;
            end else begin
              // Store the character, fetch the cursor's successor
              char_we   = 1'b1;
              rd_addr   = cur_m1[ADDR_W-1:0];
              state_nxt = ST_INS_LINK;
            end
          end else if (count_r == '0) begin
            // Empty line: one flagged result, then clear
            out_valid_nxt             = 1'b1;
            out_res_nxt.text_byte     = '0;
            out_res_nxt.last_of_line  = 1'b1;
            out_res_nxt.line_empty    = 1'b1;
            out_res_nxt.overflow_seen = ovf_r;
            head_nxt   = '0;
            cursor_nxt = '0;
            tail_nxt   = '0;
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
          end else begin
            // Start the walk at the first node
            rd_addr   = head_m1[ADDR_W-1:0];
            rem_nxt   = count_r;
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_INS_LINK: begin
        // Link the new slot to the cursor's old successor
        succ_nxt   = (cursor_r == '0) ? head_r : link_rdata;
        link_we    = 1'b1;
        link_waddr = new_m1[ADDR_W-1:0];
        link_wdata = (cursor_r == '0) ? head_r : link_rdata;
        if (cursor_r == '0) begin
          head_nxt   = new_slot;
          if (tail_r == '0) begin
            tail_nxt = new_slot;
          end
          cursor_nxt = new_slot;
          count_nxt  = new_slot;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_INS_CUR;
        end
      end

      ST_INS_CUR: begin
        // Point the cursor's node at the new slot and advance
        link_we    = 1'b1;
        link_waddr = cur_m1[ADDR_W-1:0];
        link_wdata = new_slot;
        if (tail_r == cursor_r) begin
          tail_nxt = new_slot;
        end
        cursor_nxt = new_slot;
        count_nxt  = new_slot;
        state_nxt  = ST_IDLE;
      end

      ST_EMIT: begin
        // Emit the current node and fetch the next one
        rd_addr                   = lrd_m1[ADDR_W-1:0];
        out_valid_nxt             = 1'b1;
        out_res_nxt.text_byte     = char_rdata;
        out_res_nxt.last_of_line  = (rem_r == ONE);
        out_res_nxt.line_empty    = 1'b0;
        out_res_nxt.overflow_seen = ovf_r;
        rem_nxt                   = rem_r - ONE;
        if (rem_r == ONE) begin
          head_nxt   = '0;
          cursor_nxt = '0;
          tail_nxt   = '0;
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cursor_r    <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cursor_r    <= cursor_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    succ_r    <= succ_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Fill count never exceeds capacity; cursor and tail stay on stored slots
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CAP) && (cursor_r <= count_r) && (tail_r <= count_r))
    else $error("line buffer slot bookkeeping out of range");

  // End of an empty line gives one flagged result next cycle
  a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.func == FUNC_EOL) && (count_r == '0))
      |=> (out_valid && out_res.line_empty && out_res.last_of_line))
    else $error("empty line did not produce a flagged result");

  // Results of one line come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last_of_line) |=> out_valid)
    else $error("gap inside a line's results");

  // A finished line leaves the buffer empty
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last_of_line) |-> (count_r == '0) && (head_r == '0))
    else $error("line not cleared after its last result");

endmodule : cursor_text_line_buffer_core
`default_nettype wire

@@ sv/ctlb_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module ctlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ctlb_ram
`default_nettype wire
